/* sv/spe_pkg.sv */
// shared types, constants and helpers for the stride prefetch engine
// no dependencies; imported by every module of the block
package spe_pkg;

  localparam int ADDR_BITS      = 48;
  localparam int MAX_PREFETCHES = 16;
  localparam int CNT_W          = $clog2(MAX_PREFETCHES + 1);
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int LINE_W         = 13;
  localparam int THR_W          = 5;
  localparam int PFC_W          = 5;
  localparam int APB_AW         = 4;
  localparam int APB_DW         = 32;

  localparam logic [THR_W-1:0]  REPEAT_MAX         = '1;
  localparam logic [LINE_W-1:0] RST_LINE_BYTES     = 13'd64;
  localparam logic [THR_W-1:0]  RST_GENERAL_THRESH = 5'd2;
  localparam logic [THR_W-1:0]  RST_LINE_THRESH    = 5'd2;
  localparam logic [PFC_W-1:0]  RST_PREFETCH_COUNT = 5'd4;

  typedef enum logic [1:0] {
    REG_LINE_BYTES,
    REG_GENERAL_THRESHOLD,
    REG_LINE_THRESHOLD,
    REG_PREFETCH_COUNT
  } reg_idx_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_bytes;
    logic [THR_W-1:0]  general_threshold;
    logic [THR_W-1:0]  line_threshold;
    logic [PFC_W-1:0]  prefetch_count;
  } cfg_t;

  // one run of prefetches handed from the front to the back
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic                 neg;
    logic [ADDR_BITS-1:0] step;
    logic [CNT_W-1:0]     count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // restart at 1 on a new stride, else count up and saturate
  function automatic logic [THR_W-1:0] bump(input logic [THR_W-1:0] ctr, input logic same);
    logic [THR_W-1:0] res;
    if (!same) begin
      res = THR_W'(1);
    end else if (ctr != REPEAT_MAX) begin
      res = ctr + THR_W'(1);
    end else begin
      res = REPEAT_MAX;
    end
    return res;
  endfunction

endpackage

/* sv/spe_front.sv */
// front end: takes demand addresses, tracks stride and repeat counters,
// pushes a prefetch run descriptor into the job queue; uses spe_pkg
module spe_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spe_pkg::ADDR_BITS-1:0] in_access_address,
  input  spe_pkg::cfg_t                 cfg,
  input  spe_pkg::q_stat_t              q_stat,
  output logic                          q_push,
  output spe_pkg::job_t                 q_wjob
);
  import spe_pkg::*;

  localparam int CMP_W = (CNT_W > PFC_W) ? CNT_W : PFC_W;

  logic [ADDR_BITS-1:0] prev_r, prev_nxt;
  logic                 primed_r, primed_nxt;
  logic                 stride_neg_r, stride_neg_nxt;
  logic [ADDR_BITS-1:0] stride_mag_r, stride_mag_nxt;
  logic [THR_W-1:0]     gen_rep_r, gen_rep_nxt;
  logic [THR_W-1:0]     line_rep_r, line_rep_nxt;

  logic                 accept;
  logic                 neg;
  logic [ADDR_BITS-1:0] mag;
  logic                 mag_nz;
  logic                 is_line;
  logic                 same;
  logic [THR_W-1:0]     gen_bumped;
  logic [THR_W-1:0]     line_bumped;
  logic                 trigger;
  logic [CMP_W-1:0]     pfc_ext;
  logic [CMP_W-1:0]     cnt_clamped;
  logic [CNT_W-1:0]     run_count;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    neg         = in_access_address < prev_r;
    mag         = neg ? (prev_r - in_access_address) : (in_access_address - prev_r);
    mag_nz      = (mag != '0);
    is_line     = (mag == ADDR_BITS'(cfg.line_bytes));
    same        = (neg == stride_neg_r) && (mag == stride_mag_r);
    gen_bumped  = bump(gen_rep_r, same);
    line_bumped = bump(line_rep_r, same);
    trigger     = is_line ? (line_bumped >= cfg.line_threshold)
                          : (gen_bumped >= cfg.general_threshold);

    pfc_ext     = CMP_W'(cfg.prefetch_count);
    cnt_clamped = (pfc_ext > CMP_W'(MAX_PREFETCHES)) ? CMP_W'(MAX_PREFETCHES) : pfc_ext;
    run_count   = CNT_W'(cnt_clamped);

    // line path always runs forward by one line
    q_wjob.base  = in_access_address;
    q_wjob.neg   = is_line ? 1'b0 : neg;
    q_wjob.step  = is_line ? ADDR_BITS'(cfg.line_bytes) : mag;
    q_wjob.count = run_count;
    q_push       = accept && primed_r && mag_nz && trigger && (run_count != '0);
  end

  always_comb begin
    prev_nxt       = prev_r;
    primed_nxt     = primed_r;
    stride_neg_nxt = stride_neg_r;
    stride_mag_nxt = stride_mag_r;
    gen_rep_nxt    = gen_rep_r;
    line_rep_nxt   = line_rep_r;
    if (accept) begin
      prev_nxt = in_access_address;
      if (!primed_r) begin
        primed_nxt = 1'b1;
      end else if (mag_nz) begin
        stride_neg_nxt = neg;
        stride_mag_nxt = mag;
        if (is_line) begin
          line_rep_nxt = line_bumped;
        end else begin
          gen_rep_nxt = gen_bumped;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    if (!rst_n) begin
      primed_r     <= 1'b0;
      stride_neg_r <= 1'b0;
      stride_mag_r <= '0;
      gen_rep_r    <= '0;
      line_rep_r   <= '0;
    end else begin
      primed_r     <= primed_nxt;
      stride_neg_r <= stride_neg_nxt;
      stride_mag_r <= stride_mag_nxt;
      gen_rep_r    <= gen_rep_nxt;
      line_rep_r   <= line_rep_nxt;
    end
  end

endmodule

/* sv/spe_queue.sv */
// short job queue between front and back, register based
// uses spe_pkg for the job type and depth
module spe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  spe_pkg::job_t    wjob,
  input  logic             pop,
  output spe_pkg::job_t    rjob,
  output spe_pkg::q_stat_t stat
);
  import spe_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign rjob       = slot_r[rd_ptr_r];
  assign stat.full  = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (fill_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wjob;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

/* sv/spe_back.sv */
// back end: walks one prefetch run at a time by repeated add or subtract
// of the step, drives the result register; uses spe_pkg
module spe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spe_pkg::job_t                 q_rjob,
  input  spe_pkg::q_stat_t              q_stat,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spe_pkg::ADDR_BITS-1:0] out_prefetch_address,
  output logic                          out_last_of_run
);
  import spe_pkg::*;

  logic                 active_r, active_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] step_r, step_nxt;
  logic                 neg_r, neg_nxt;
  logic [CNT_W-1:0]     remain_r, remain_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [ADDR_BITS-1:0] oaddr_r, oaddr_nxt;
  logic                 olast_r, olast_nxt;

  logic                 out_free;
  logic                 adv;
  logic                 final_one;
  logic [ADDR_BITS-1:0] step_addr;

  assign out_valid            = ovalid_r;
  assign out_prefetch_address = oaddr_r;
  assign out_last_of_run      = olast_r;

  always_comb begin
    out_free  = !ovalid_r || !out_stall;
    adv       = active_r && out_free;
    final_one = (remain_r == CNT_W'(1));
    step_addr = neg_r ? (addr_r - step_r) : (addr_r + step_r);
    // next run loads as the current one hands over its last word
    q_pop     = !q_stat.empty && (!active_r || (adv && final_one));

    active_nxt = active_r;
    addr_nxt   = addr_r;
    step_nxt   = step_r;
    neg_nxt    = neg_r;
    remain_nxt = remain_r;
    if (q_pop) begin
      active_nxt = 1'b1;
      addr_nxt   = q_rjob.base;
      step_nxt   = q_rjob.step;
      neg_nxt    = q_rjob.neg;
      remain_nxt = q_rjob.count;
    end else if (adv) begin
      addr_nxt   = step_addr;
      remain_nxt = remain_r - CNT_W'(1);
      if (final_one) begin
        active_nxt = 1'b0;
      end
    end

    ovalid_nxt = ovalid_r;
    oaddr_nxt  = oaddr_r;
    olast_nxt  = olast_r;
    if (out_free) begin
      ovalid_nxt = adv;
      if (adv) begin
        oaddr_nxt = step_addr;
        olast_nxt = final_one;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    step_r   <= step_nxt;
    neg_r    <= neg_nxt;
    remain_r <= remain_nxt;
    oaddr_r  <= oaddr_nxt;
    olast_r  <= olast_nxt;
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

/* sv/stride_prefetch_engine.sv */
// top level of the stride prefetch engine: register port, front, queue, back
// depends on spe_pkg, spe_front, spe_queue and spe_back
//
// One demand address is taken per cycle as long as the four-entry job queue
// has room. An address whose stride has repeated often enough queues one run
// of min(prefetch_count, 16) prefetch addresses; the back end sends one word
// per cycle while the receiver does not stall, with no gap between queued
// runs, so a triggering address fills the result channel with one word per
// prefetch (four at reset) and a non-triggering one yields no words. The first
// address after reset only primes the tracker.
// Registers sit at byte offsets 0x0 line_bytes, 0x4 general_threshold,
// 0x8 line_threshold, 0xc prefetch_count; the user must write them only
// while the block is idle, which the block itself does not enforce.
module stride_prefetch_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spe_pkg::ADDR_BITS-1:0] in_access_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spe_pkg::ADDR_BITS-1:0] out_prefetch_address,
  output logic                          out_last_of_run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spe_pkg::APB_AW-1:0]    paddr,
  input  logic [spe_pkg::APB_DW-1:0]    pwdata,
  output logic [spe_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import spe_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_sel;
  logic     wr_en;

  job_t     q_wjob;
  job_t     q_rjob;
  q_stat_t  q_stat;
  logic     q_push;
  logic     q_pop;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (reg_sel)
      REG_LINE_BYTES: begin
        prdata = APB_DW'(cfg_r.line_bytes);
        if (wr_en) cfg_nxt.line_bytes = pwdata[LINE_W-1:0];
      end
      REG_GENERAL_THRESHOLD: begin
        prdata = APB_DW'(cfg_r.general_threshold);
        if (wr_en) cfg_nxt.general_threshold = pwdata[THR_W-1:0];
      end
      REG_LINE_THRESHOLD: begin
        prdata = APB_DW'(cfg_r.line_threshold);
        if (wr_en) cfg_nxt.line_threshold = pwdata[THR_W-1:0];
      end
      REG_PREFETCH_COUNT: begin
        prdata = APB_DW'(cfg_r.prefetch_count);
        if (wr_en) cfg_nxt.prefetch_count = pwdata[PFC_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_bytes        <= RST_LINE_BYTES;
      cfg_r.general_threshold <= RST_GENERAL_THRESH;
      cfg_r.line_threshold    <= RST_LINE_THRESH;
      cfg_r.prefetch_count    <= RST_PREFETCH_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spe_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_access_address (in_access_address),
    .cfg               (cfg_r),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_wjob            (q_wjob)
  );

  spe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wjob  (q_wjob),
    .pop   (q_pop),
    .rjob  (q_rjob),
    .stat  (q_stat)
  );

  spe_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_rjob               (q_rjob),
    .q_stat               (q_stat),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_prefetch_address (out_prefetch_address),
    .out_last_of_run      (out_last_of_run)
  );

endmodule

/* tb/stride_prefetch_engine_test.sv */
// self-checking testbench for the stride prefetch engine: directed cases, random traffic and
// backpressure; predicts every prefetch word from its own tracker copy, compares in order
// depends on spe_pkg and stride_prefetch_engine
`timescale 1ns / 100ps

module stride_prefetch_engine_test;
  import spe_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 24;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic                 last;
  } prefetch_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_BITS-1:0] in_access_address = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ADDR_BITS-1:0] out_prefetch_address;
  logic                 out_last_of_run;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  // tracker copy: registers
  logic [LINE_W-1:0] line_bytes_r;
  logic [THR_W-1:0]  general_thr_r;
  logic [THR_W-1:0]  line_thr_r;
  logic [PFC_W-1:0]  pf_count_r;
  // tracker copy: state
  logic [ADDR_BITS-1:0] last_addr;
  logic                 seen_first;
  logic                 stride_neg;
  logic [ADDR_BITS-1:0] stride_mag;
  logic [THR_W-1:0]     general_repeats;
  logic [THR_W-1:0]     line_repeats;

  prefetch_word_t pending_prefetches[$];

  int unsigned cycles = 0;
  int mismatches = 0;
  int accesses_taken = 0;
  int words_checked = 0;
  int input_held_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  logic [ADDR_BITS-1:0] last_sent = '0;

  stride_prefetch_engine dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_access_address    (in_access_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_prefetch_address (out_prefetch_address),
    .out_last_of_run      (out_last_of_run),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               pending_prefetches.size());
      $display("FAIL stride_prefetch_engine");
      $finish;
    end
  end

  function automatic logic [ADDR_BITS-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[ADDR_BITS-1:0];
  endfunction

  function automatic void note_mismatch(input string what, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, exp_v, act_v);
  endfunction

  function automatic void reset_tracker();
    line_bytes_r    = RST_LINE_BYTES;
    general_thr_r   = RST_GENERAL_THRESH;
    line_thr_r      = RST_LINE_THRESH;
    pf_count_r      = RST_PREFETCH_COUNT;
    last_addr       = '0;
    seen_first      = 1'b0;
    stride_neg      = 1'b0;
    stride_mag      = '0;
    general_repeats = '0;
    line_repeats    = '0;
  endfunction

  function automatic logic [THR_W-1:0] next_repeat(input logic [THR_W-1:0] cnt,
                                                   input logic same);
    if (!same) return THR_W'(1);
    if (cnt == '1) return cnt;
    return cnt + THR_W'(1);
  endfunction

  function automatic void queue_run(input logic [ADDR_BITS-1:0] base, input logic down,
                                    input logic [ADDR_BITS-1:0] step);
    int n;
    logic [ADDR_BITS-1:0] off;
    prefetch_word_t w;
    n = (pf_count_r > MAX_PREFETCHES) ? MAX_PREFETCHES : int'(pf_count_r);
    for (int i = 1; i <= n; i++) begin
      off = step * ADDR_BITS'(i);
      w.addr = down ? base - off : base + off;
      w.last = (i == n);
      pending_prefetches = {pending_prefetches, w};
    end
  endfunction

  function automatic void predict_access(input logic [ADDR_BITS-1:0] cur);
    logic [ADDR_BITS-1:0] prev;
    logic [ADDR_BITS-1:0] mag;
    logic down;
    logic same;
    prev = last_addr;
    last_addr = cur;
    if (!seen_first) begin
      seen_first = 1'b1;
      return;
    end
    if (cur >= prev) begin
      down = 1'b0;
      mag = cur - prev;
    end else begin
      down = 1'b1;
      mag = prev - cur;
    end
    if (mag == '0) return;
    same = (down == stride_neg) && (mag == stride_mag);
    stride_neg = down;
    stride_mag = mag;
    if (mag == ADDR_BITS'(line_bytes_r)) begin
      line_repeats = next_repeat(line_repeats, same);
      // line runs always step forward
      if (line_repeats >= line_thr_r) queue_run(cur, 1'b0, ADDR_BITS'(line_bytes_r));
    end else begin
      general_repeats = next_repeat(general_repeats, same);
      if (general_repeats >= general_thr_r) queue_run(cur, down, mag);
    end
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(input reg_idx_t idx);
    case (idx)
      REG_LINE_BYTES:        return APB_DW'(line_bytes_r);
      REG_GENERAL_THRESHOLD: return APB_DW'(general_thr_r);
      REG_LINE_THRESHOLD:    return APB_DW'(line_thr_r);
      default:               return APB_DW'(pf_count_r);
    endcase
  endfunction

  // input monitor feeds the tracker, output monitor checks words in order
  always @(posedge clk) begin
    prefetch_word_t want;
    if (rst_n) begin
      if (in_valid && in_stall) input_held_cycles++;
      if (in_valid && !in_stall) begin
        accesses_taken++;
        predict_access(in_access_address);
      end
      if (out_valid && !out_stall) begin
        words_checked++;
        if (pending_prefetches.size() == 0) begin
          note_mismatch("unexpected word", 64'd0, 64'(out_prefetch_address));
        end else begin
          want = pending_prefetches.pop_front();
          if (out_prefetch_address !== want.addr)
            note_mismatch("prefetch_address", 64'(want.addr), 64'(out_prefetch_address));
          if (out_last_of_run !== want.last)
            note_mismatch("last_of_run", 64'(want.last), 64'(out_last_of_run));
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_access(input logic [ADDR_BITS-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_access_address <= a;
    last_sent = a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_prefetches.size() != 0) @(posedge clk);
    // extra margin once every expected word has been checked
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_LINE_BYTES:        line_bytes_r = val[LINE_W-1:0];
      REG_GENERAL_THRESHOLD: general_thr_r = val[THR_W-1:0];
      REG_LINE_THRESHOLD:    line_thr_r = val[THR_W-1:0];
      default:               pf_count_r = val[PFC_W-1:0];
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reg_check(input reg_idx_t idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_AW'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== reg_value(idx)) note_mismatch(idx.name(), 64'(reg_value(idx)), 64'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int lb, input int gthr, input int lthr, input int cnt);
    wait_idle();
    reg_write(REG_LINE_BYTES, APB_DW'(lb));
    reg_write(REG_GENERAL_THRESHOLD, APB_DW'(gthr));
    reg_write(REG_LINE_THRESHOLD, APB_DW'(lthr));
    reg_write(REG_PREFETCH_COUNT, APB_DW'(cnt));
  endtask

  task automatic test_registers();
    reg_idx_t idx;
    idx = idx.first();
    do begin
      reg_check(idx);
      idx = idx.next();
    end while (idx != idx.first());
    set_config(4096, 31, 0, 16);
    reg_check(REG_LINE_BYTES);
    reg_check(REG_GENERAL_THRESHOLD);
    reg_check(REG_LINE_THRESHOLD);
    reg_check(REG_PREFETCH_COUNT);
    set_config(64, 2, 2, 4);
  endtask

  // priming, zero distance, forward and backward line strides
  task automatic test_line_path();
    send_access(48'h0000_0000_1000);
    send_access(48'h0000_0000_1000);
    send_access(48'h0000_0000_1040);
    send_access(48'h0000_0000_1080);
    send_access(48'h0000_0000_10c0);
    send_access(48'h0000_0000_1080);
    send_access(48'h0000_0000_1040);
  endtask

  // general strides whose runs wrap past the top and below zero
  task automatic test_general_wrap();
    set_config(64, 2, 2, 16);
    send_access(48'hffff_ffff_ff00);
    send_access(48'hffff_ffff_ff30);
    send_access(48'hffff_ffff_ff60);
    send_access(48'h0000_0000_0100);
    send_access(48'h0000_0000_00f0);
    send_access(48'h0000_0000_00e0);
  endtask

  task automatic test_thresholds_counts();
    set_config(64, 0, 0, 0);
    send_access(48'h0000_0000_0000);
    send_access(48'h0000_0000_0040);
    send_access(48'h0000_0000_0007);
    set_config(64, 0, 0, 17);
    send_access(48'h0000_0000_0047);
    set_config(64, 0, 0, 31);
    send_access(48'hffff_ffff_ffff);
    set_config(64, 0, 0, 1);
    send_access(48'h0000_0000_0000);
  endtask

  // both counters run into saturation
  task automatic test_saturation();
    logic [ADDR_BITS-1:0] a;
    set_config(64, 31, 31, 1);
    a = 48'h0000_1234_0000;
    for (int i = 0; i < 34; i++) begin
      a = a + 48'd64;
      send_access(a);
    end
    for (int i = 0; i < 34; i++) begin
      a = a - 48'd24;
      send_access(a);
    end
  endtask

  task automatic test_line_size();
    set_config(0, 1, 1, 2);
    send_access(48'h0000_0000_8000);
    send_access(48'h0000_0000_8005);
    send_access(48'h0000_0000_800a);
    set_config(4096, 1, 1, 2);
    send_access(48'h0000_0001_0000);
    send_access(48'h0000_0000_f000);
    set_config(1, 1, 1, 2);
    send_access(48'h0000_0000_f001);
  endtask

  // mostly stride runs with random content, some noise and broken runs
  task automatic run_random_traffic(input int n_items);
    int sent;
    int kind;
    int len;
    logic down;
    logic [ADDR_BITS-1:0] step;
    logic [ADDR_BITS-1:0] a;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      down = 1'($urandom_range(0, 1));
      a = ($urandom_range(0, 3) == 0) ? rand48() : last_sent;
      len = $urandom_range(2, 10);
      case (kind)
        0:       step = rand48();
        1, 2, 3: step = (line_bytes_r == '0) ? ADDR_BITS'(1) : ADDR_BITS'(line_bytes_r);
        4, 5, 6: step = ADDR_BITS'($urandom_range(1, 300));
        7, 8:    step = rand48();
        default: step = '0;
      endcase
      if (kind == 0) len = 1;
      for (int i = 0; i < len && sent < n_items; i++) begin
        if ($urandom_range(0, 15) == 0) begin
          send_access(rand48());
        end else begin
          a = down ? a - step : a + step;
          send_access(a);
        end
        sent++;
      end
    end
  endtask

  task automatic test_random();
    send_idle_pct = 7;
    recv_idle_pct = 75;
    set_config(1, 1, 3, 3);
    run_random_traffic(70);
    send_idle_pct = 75;
    recv_idle_pct = 7;
    set_config(4096, 0, 0, 16);
    run_random_traffic(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config($urandom_range(1, 4096), $urandom_range(0, 4), $urandom_range(0, 4),
               $urandom_range(0, 16));
    run_random_traffic(70);
  endtask

  // long receiver hold-off while every word triggers a full run
  task automatic test_backpressure();
    logic [ADDR_BITS-1:0] a;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(64, 0, 0, 16);
    hold_request = 400;
    a = rand48();
    for (int i = 0; i < 60; i++) begin
      a = a + 48'd64;
      send_access(a);
    end
  endtask

  initial begin
    reset_tracker();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 7;
    recv_idle_pct = 75;
    test_registers();
    test_line_path();
    test_general_wrap();
    test_thresholds_counts();
    test_saturation();
    test_line_size();
    test_random();
    test_backpressure();
    wait_idle();
    if (pending_prefetches.size() != 0) mismatches += pending_prefetches.size();
    $display("covered %0d accesses and %0d prefetch words over several register settings",
             accesses_taken, words_checked);
    $display("input held off for %0d cycles under backpressure, %0d mismatches",
             input_held_cycles, mismatches);
    if (mismatches == 0) begin
      $display("PASS stride_prefetch_engine");
    end else begin
      $display("FAIL stride_prefetch_engine");
    end
    $finish;
  end

endmodule

/* files.f */
sv/spe_pkg.sv
sv/spe_front.sv
sv/spe_queue.sv
sv/spe_back.sv
sv/stride_prefetch_engine.sv
tb/stride_prefetch_engine_test.sv
